@@ rtl/mbps_pkg.sv @@
// package for the masked byte pattern search
// sizes, configuration register indexes and the cell control struct
// no dependencies
`default_nettype none

package mbps_pkg;

    localparam int MAX_PATTERN    = 16;
    localparam int OFFSET_BITS    = 32;
    localparam int WIN_DEPTH      = MAX_PATTERN - 1;
    localparam int LEN_W          = $clog2(MAX_PATTERN + 1);
    localparam int REG_BYTES      = 16;
    localparam int LEN_REG_W      = 5;
    localparam int CARE_W         = 16;
    localparam int MATCH_OFFSET_W = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_CARE_MASK      = 2'd2,
        CFG_PATTERN_LENGTH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ rtl/mbps_in_if.sv @@
// input channel of the masked byte pattern search
// one transaction carries one byte of the scanned region
// no dependencies
`default_nettype none

interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       region_end;

    modport source (output valid, output data_byte, output region_end, input ready);
    modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

`default_nettype wire

@@ rtl/mbps_out_if.sv @@
// result channel of the masked byte pattern search
// one transaction carries one search result
// no dependencies
`default_nettype none

interface mbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

@@ rtl/mbps_cell.sv @@
// one window cell: holds an earlier byte, passes it on, masked compare
// depends on mbps_pkg
`default_nettype none

module mbps_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mbps_pkg::t_cell_ctrl i_ctrl,
    input  wire  [7:0]           i_byte,
    input  wire  [7:0]           i_want,
    input  wire                  i_care,
    output logic [7:0]           o_byte,
    output logic                 o_ok
);
    import mbps_pkg::*;

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'd0;
        end else if (i_ctrl.clear) begin
            r_byte <= 8'd0;
        end else if (i_ctrl.shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_ok   = !i_care || (r_byte == i_want);

endmodule

`default_nettype wire

@@ rtl/masked_byte_pattern_search.sv @@
// top level of the masked byte pattern search
// depends on mbps_pkg, mbps_in_if, mbps_out_if and mbps_cell
//
// The block takes one byte of the region per clock cycle while input is not
// stalled, and registers a result in its output stage for the transaction that
// completes a match or ends the region before one is found. The pattern is
// checked combinationally against the new byte and a row of MAX_PATTERN-1
// window cells, which sets that rate. A two-entry output stage lets input
// continue while a result waits; input stalls only when both entries are held.
// The user must write configuration through i_cfg_we, i_cfg_index and i_cfg_data
// only while no search is in progress, not enforced by the block; it applies to the next byte.
`default_nettype none

module masked_byte_pattern_search (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [mbps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [mbps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    mbps_in_if.sink                            i_item,
    mbps_out_if.source                         o_result
);
    import mbps_pkg::*;

    localparam int TAPS = MAX_PATTERN;
    localparam int MAXW = (OFFSET_BITS > MATCH_OFFSET_W) ? OFFSET_BITS : MATCH_OFFSET_W;
    localparam int CMPW = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;

    // configuration registers
    logic [CFG_DATA_W-1:0] r_pattern_low;
    logic [CFG_DATA_W-1:0] r_pattern_high;
    logic [CARE_W-1:0]     r_care_mask;
    logic [LEN_REG_W-1:0]  r_pattern_length;

    // scan state
    logic [OFFSET_BITS-1:0] r_pos;
    logic                   r_reported;

    // output stage
    logic                      r_out_valid;
    logic                      r_out_found;
    logic [MATCH_OFFSET_W-1:0] r_out_offset;
    logic                      r_skid_valid;
    logic                      r_skid_found;
    logic [MATCH_OFFSET_W-1:0] r_skid_offset;

    logic [CMPW-1:0]            w_len_wide;
    logic [LEN_W-1:0]           w_len;
    logic [LEN_W-1:0]           w_len_m1;
    logic [2*CFG_DATA_W-1:0]    w_pat;
    logic [LEN_W-1:0]           w_pidx [TAPS];
    logic [7:0]                 w_want [TAPS];
    logic                       w_care [TAPS];
    logic [TAPS-1:0]            w_ok;
    logic [7:0]                 w_cell_in  [WIN_DEPTH];
    logic [7:0]                 w_cell_out [WIN_DEPTH];
    t_cell_ctrl                 w_ctrl;
    logic                       w_acc;
    logic                       w_last;
    logic                       w_pos_ok;
    logic                       w_hit;
    logic                       w_push;
    logic [MAXW-1:0]            w_off_wide;
    logic [MATCH_OFFSET_W-1:0]  w_res_offset;
    logic                       w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_care_mask      <= '0;
            r_pattern_length <= LEN_REG_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_LOW:    r_pattern_low    <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_data;
                CFG_CARE_MASK:      r_care_mask      <= i_cfg_data[CARE_W-1:0];
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[LEN_REG_W-1:0];
            endcase
        end
    end

    // active length, clamped to 1..MAX_PATTERN
    always_comb begin
        w_len_wide = CMPW'(r_pattern_length);
        if (w_len_wide == '0) begin
            w_len_wide = CMPW'(1);
        end else if (w_len_wide > CMPW'(MAX_PATTERN)) begin
            w_len_wide = CMPW'(MAX_PATTERN);
        end
        w_len    = LEN_W'(w_len_wide);
        w_len_m1 = w_len - LEN_W'(1);
    end

    // pattern byte and care bit aligned to each tap; tap 0 is the new byte
    assign w_pat = {r_pattern_high, r_pattern_low};

    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            w_pidx[k] = w_len_m1 - LEN_W'(k);
            w_want[k] = 8'd0;
            w_care[k] = 1'b0;
            for (int i = 0; i < REG_BYTES; i++) begin
                if ((LEN_W'(k) < w_len) && (int'(w_pidx[k]) == i)) begin
                    w_want[k] = w_pat[8*i +: 8];
                    w_care[k] = r_care_mask[i];
                end
            end
        end
    end

    assign w_acc  = i_item.valid && i_item.ready;
    assign w_last = i_item.region_end;

    assign w_ctrl.clear = w_acc && w_last;
    assign w_ctrl.shift = w_acc && !r_reported && !w_hit;

    always_comb begin
        w_cell_in[0] = i_item.data_byte;
        for (int j = 1; j < WIN_DEPTH; j++) begin
            w_cell_in[j] = w_cell_out[j-1];
        end
    end

    assign w_ok[0] = !w_care[0] || (i_item.data_byte == w_want[0]);

    for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
        mbps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_byte  (w_cell_in[j]),
            .i_want  (w_want[j+1]),
            .i_care  (w_care[j+1]),
            .o_byte  (w_cell_out[j]),
            .o_ok    (w_ok[j+1])
        );
    end

    assign w_pos_ok     = MAXW'(r_pos) >= MAXW'(w_len_m1);
    assign w_hit        = !r_reported && w_pos_ok && (&w_ok);
    assign w_push       = w_acc && !r_reported && (w_hit || w_last);
    assign w_off_wide   = MAXW'(r_pos) - MAXW'(w_len_m1);
    assign w_res_offset = w_hit ? w_off_wide[MATCH_OFFSET_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_reported <= 1'b0;
        end else if (w_acc) begin
            if (w_last) begin
                r_pos      <= '0;
                r_reported <= 1'b0;
            end else if (!r_reported) begin
                if (w_hit) begin
                    r_reported <= 1'b1;
                end else if (r_pos != '1) begin
                    r_pos <= r_pos + OFFSET_BITS'(1);
                end
            end
        end
    end

    // two-entry output stage
    assign w_pop = r_out_valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_found  <= r_skid_found;
                r_out_offset <= r_skid_offset;
            end else begin
                r_out_found  <= w_hit;
                r_out_offset <= w_res_offset;
            end
        end else if (w_push) begin
            r_skid_found  <= w_hit;
            r_skid_offset <= w_res_offset;
        end
    end

    assign i_item.ready          = !r_skid_valid;
    assign o_result.valid        = r_out_valid;
    assign o_result.found        = r_out_found;
    assign o_result.match_offset = r_out_offset;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_last) |=> (r_pos == '0 && !r_reported))
        else $error("scan state not cleared after region end");

    a_hit_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_hit && !w_last) |=> r_reported)
        else $error("match not recorded as reported");

endmodule

`default_nettype wire
